### sv/psvb_pkg.sv
`timescale 1ns / 1ps

package psvb_pkg;

    // Defaults for the top-level parameters.
    localparam int VOICES_DEF      = 120;
    localparam int STORE_DEPTH_DEF = 131072;
    localparam int MAX_LINE_DEF    = 2756;

    // Fixed widths that cover the whole parameter ranges.
    localparam int VOICE_W   = 7;   // up to 128 voices
    localparam int ELEM_W    = 12;  // element index below 4096
    localparam int LEN_W     = 13;  // line length up to 4096
    localparam int ACC_W     = 23;  // sum of up to 128 signed 16-bit steps
    localparam int CNT_W     = 8;   // active count up to 128
    localparam int CFG_IDX_W = 2;
    localparam int CNT40_W   = 40;

    localparam logic [CFG_IDX_W-1:0] REG_DAMPING = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LIFE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SEED    = 2'd2;

    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_PLUCK = 1'b1;

    localparam logic [14:0] GAIN_RST   = 15'd16318;
    localparam logic [9:0]  LIFE_RST   = 10'd450;
    localparam logic [31:0] LFSR_TAPS  = 32'h8020_0003;
    localparam logic signed [15:0] MIX_SCALE = 16'sd32766;

    localparam int ROM_ENTRIES = 120;
    localparam logic [11:0] LEN_ROM [ROM_ENTRIES] = '{
        12'd2756, 12'd2756, 12'd2756, 12'd2756, 12'd2756, 12'd2756,
        12'd2756, 12'd2756, 12'd2756, 12'd2756, 12'd2756, 12'd2756,
        12'd2697, 12'd2546, 12'd2403, 12'd2268, 12'd2141, 12'd2020,
        12'd1907, 12'd1800, 12'd1699, 12'd1604, 12'd1514, 12'd1429,
        12'd1348, 12'd1273, 12'd1201, 12'd1134, 12'd1070, 12'd1010,
        12'd954, 12'd900, 12'd849, 12'd802, 12'd757, 12'd714,
        12'd674, 12'd636, 12'd601, 12'd567, 12'd535, 12'd505,
        12'd477, 12'd450, 12'd425, 12'd401, 12'd378, 12'd357,
        12'd337, 12'd318, 12'd300, 12'd283, 12'd268, 12'd253,
        12'd238, 12'd225, 12'd212, 12'd200, 12'd189, 12'd179,
        12'd169, 12'd159, 12'd150, 12'd142, 12'd134, 12'd126,
        12'd119, 12'd113, 12'd106, 12'd100, 12'd95, 12'd89,
        12'd84, 12'd80, 12'd75, 12'd71, 12'd67, 12'd63,
        12'd60, 12'd56, 12'd53, 12'd50, 12'd47, 12'd45,
        12'd42, 12'd40, 12'd38, 12'd35, 12'd33, 12'd32,
        12'd30, 12'd28, 12'd27, 12'd25, 12'd24, 12'd22,
        12'd21, 12'd20, 12'd19, 12'd18, 12'd17, 12'd16,
        12'd15, 12'd14, 12'd13, 12'd13, 12'd12, 12'd11,
        12'd11, 12'd10, 12'd9, 12'd9, 12'd8, 12'd8,
        12'd7, 12'd7, 12'd7, 12'd6, 12'd6, 12'd6
    };

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic              latch;
        logic              start_tick;
        logic              rd_voice;
        logic              rd_a;
        logic              rd_b;
        logic              mul;
        logic              wr_step;
        logic              fill;
        logic              pluck_end;
        logic              mix;
        logic              out;
        logic [VOICE_W-1:0] voice;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic             active;
        logic [LEN_W-1:0] len;
    } t_stat;

    function automatic int line_len(input int v, input int max_line);
        int n;
        n = (v < ROM_ENTRIES) ? int'(LEN_ROM[v]) : int'(LEN_ROM[ROM_ENTRIES-1]);
        return (n > max_line) ? max_line : n;
    endfunction

    // A line length never exceeds the store depth, so one subtraction wraps.
    function automatic int line_base(input int v, input int max_line, input int depth);
        int b;
        b = 0;
        for (int j = 0; j < v; j++) begin
            b = b + line_len(j, max_line);
            if (b >= depth) begin
                b = b - depth;
            end
        end
        return b;
    endfunction

    function automatic logic [31:0] lfsr_next(input logic [31:0] s);
        logic [31:0] t;
        t = {1'b0, s[31:1]};
        return s[0] ? (t ^ LFSR_TAPS) : t;
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [47:0] x);
        logic signed [15:0] r;
        if (x > 48'sd32767) begin
            r = 16'sh7fff;
        end else if (x < -48'sd32768) begin
            r = -16'sh8000;
        end else begin
            r = x[15:0];
        end
        return r;
    endfunction

endpackage

### sv/psvb_ctrl.sv
`timescale 1ns / 1ps

module psvb_ctrl import psvb_pkg::*; #(
    parameter int VOICES = VOICES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic               i_opcode,
    input  logic [VOICE_W-1:0] i_note_number,
    input  t_stat              i_stat,
    output t_cmd               o_cmd,
    output logic               o_busy
);

    typedef enum logic [3:0] {
        S_IDLE, S_FILL, S_PEND, S_CHK, S_PTR, S_A, S_B, S_W, S_MIX, S_OUT
    } t_state;

    t_state             r_state;
    logic [VOICE_W-1:0] r_voice;
    logic [ELEM_W-1:0]  r_elem;
    logic               w_accept;
    logic               w_last_voice;

    assign w_accept     = i_start && (r_state == S_IDLE);
    assign w_last_voice = (r_voice == VOICE_W'(VOICES - 1));
    assign o_busy       = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_voice <= '0;
            r_elem  <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_elem <= '0;
                        if (i_opcode == OP_PLUCK) begin
                            r_voice <= i_note_number;
                            if (int'(i_note_number) < VOICES) begin
                                r_state <= S_FILL;
                            end
                        end else begin
                            r_voice <= '0;
                            r_state <= S_CHK;
                        end
                    end
                end
                S_FILL: begin
                    if (r_elem == ELEM_W'(i_stat.len - LEN_W'(1))) begin
                        r_state <= S_PEND;
                    end else begin
                        r_elem <= r_elem + ELEM_W'(1);
                    end
                end
                S_PEND: r_state <= S_IDLE;
                S_CHK: begin
                    if (i_stat.active) begin
                        r_state <= S_PTR;
                    end else if (w_last_voice) begin
                        r_state <= S_MIX;
                    end else begin
                        r_voice <= r_voice + VOICE_W'(1);
                    end
                end
                S_PTR: r_state <= S_A;
                S_A:   r_state <= S_B;
                S_B:   r_state <= S_W;
                S_W: begin
                    if (w_last_voice) begin
                        r_state <= S_MIX;
                    end else begin
                        r_voice <= r_voice + VOICE_W'(1);
                        r_state <= S_CHK;
                    end
                end
                S_MIX:   r_state <= S_OUT;
                S_OUT:   r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_comb begin
        o_cmd            = '0;
        o_cmd.voice      = r_voice;
        o_cmd.latch      = w_accept;
        o_cmd.start_tick = w_accept && (i_opcode == OP_TICK);
        o_cmd.fill       = (r_state == S_FILL);
        o_cmd.pluck_end  = (r_state == S_PEND);
        o_cmd.rd_voice   = (r_state == S_CHK);
        o_cmd.rd_a       = (r_state == S_PTR);
        o_cmd.rd_b       = (r_state == S_A);
        o_cmd.mul        = (r_state == S_B);
        o_cmd.wr_step    = (r_state == S_W);
        o_cmd.mix        = (r_state == S_MIX);
        o_cmd.out        = (r_state == S_OUT);
    end

endmodule

### sv/psvb_dp.sv
`timescale 1ns / 1ps

module psvb_dp import psvb_pkg::*; #(
    parameter int VOICES      = VOICES_DEF,
    parameter int STORE_DEPTH = STORE_DEPTH_DEF,
    parameter int MAX_LINE    = MAX_LINE_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data,
    input  logic [14:0]          i_volume,
    input  t_cmd                 i_cmd,
    output t_stat                o_stat,
    output logic signed [15:0]   o_audio_sample,
    output logic [6:0]           o_voices_active,
    output logic                 o_strobe
);

    localparam int ADDR_W = $clog2(STORE_DEPTH);
    localparam int VIDX_W = (VOICES > 1) ? $clog2(VOICES) : 1;

    logic [ADDR_W-1:0] w_base [VOICES];
    logic [LEN_W-1:0]  w_len  [VOICES];

    for (genvar gv = 0; gv < VOICES; gv++) begin : g_tab
        assign w_base[gv] = ADDR_W'(line_base(gv, MAX_LINE, STORE_DEPTH));
        assign w_len[gv]  = LEN_W'(line_len(gv, MAX_LINE));
    end

    function automatic logic [ADDR_W-1:0] addr_wrap(input logic [ADDR_W-1:0] base,
                                                     input logic [ELEM_W-1:0] off);
        logic [ADDR_W:0] s;
        s = {1'b0, base} + (ADDR_W + 1)'(off);
        if (s >= (ADDR_W + 1)'(STORE_DEPTH)) begin
            s = s - (ADDR_W + 1)'(STORE_DEPTH);
        end
        return s[ADDR_W-1:0];
    endfunction

    logic signed [15:0]        r_store [STORE_DEPTH];
    logic [ELEM_W-1:0]         r_ptr_mem [VOICES];
    logic [CNT40_W-1:0]        r_exp_mem [VOICES];

    logic [14:0]               r_gain;
    logic [9:0]                r_life;
    logic [31:0]               r_lfsr;
    logic [14:0]               r_vol;
    logic [VOICES-1:0]         r_pvalid;
    logic [VOICES-1:0]         r_active;
    logic [ELEM_W-1:0]         r_ptr_q;
    logic [CNT40_W-1:0]        r_exp_q;
    logic signed [15:0]        r_store_q;
    logic [ADDR_W-1:0]         r_pa;
    logic [ELEM_W-1:0]         r_nxt;
    logic [ELEM_W-1:0]         r_elem;
    logic signed [15:0]        r_a;
    logic signed [32:0]        r_prod;
    logic signed [ACC_W-1:0]   r_acc;
    logic [CNT_W-1:0]          r_cnt;
    logic signed [38:0]        r_mix;
    logic [CNT40_W-1:0]        r_scount;
    logic                      r_fill_pend;
    logic [ADDR_W-1:0]         r_fill_addr;
    logic signed [15:0]        r_fill_data;

    logic [VIDX_W-1:0]         w_vi;
    logic [LEN_W-1:0]          w_len_cur;
    logic [ELEM_W-1:0]         w_ptr;
    logic [LEN_W-1:0]          w_ptr_inc;
    logic [ELEM_W-1:0]         w_nxt;
    logic [ADDR_W-1:0]         w_pa;
    logic [ADDR_W-1:0]         w_rd_addr;
    logic [31:0]               w_lfsr_n;
    logic signed [31:0]        w_fprod;
    logic signed [16:0]        w_sum;
    logic signed [15:0]        w_y;
    logic [CNT40_W-1:0]        w_diff;
    logic                      w_retire;

    assign w_vi      = i_cmd.voice[VIDX_W-1:0];
    assign w_len_cur = w_len[w_vi];
    assign o_stat.len    = w_len_cur;
    assign o_stat.active = r_active[w_vi];

    always_comb begin
        w_ptr = r_pvalid[w_vi] ? r_ptr_q : '0;
        if ({1'b0, w_ptr} >= w_len_cur) begin
            w_ptr = '0;
        end
        w_ptr_inc = {1'b0, w_ptr} + LEN_W'(1);
        w_nxt = (w_ptr_inc >= w_len_cur) ? '0 : w_ptr_inc[ELEM_W-1:0];
    end

    assign w_pa      = addr_wrap(w_base[w_vi], w_ptr);
    assign w_rd_addr = i_cmd.rd_a ? w_pa : addr_wrap(w_base[w_vi], r_nxt);

    assign w_lfsr_n = lfsr_next(r_lfsr);
    assign w_fprod  = $signed(w_lfsr_n[31:16]) * $signed({1'b0, r_vol});
    assign w_sum    = 17'(r_a) + 17'(r_store_q);
    assign w_y      = sat16(48'(r_prod >>> 15));
    assign w_diff   = (r_scount + CNT40_W'(1)) - r_exp_q;
    assign w_retire = !w_diff[CNT40_W-1];

    // Delay-line store: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (r_fill_pend) begin
            r_store[r_fill_addr] <= r_fill_data;
        end else if (i_cmd.wr_step) begin
            r_store[r_pa] <= w_y;
        end
        r_store_q <= r_store[w_rd_addr];
    end

    // Per-voice pointer and expiry memories.
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_step) begin
            r_ptr_mem[w_vi] <= r_nxt;
        end
        if (i_cmd.pluck_end) begin
            r_exp_mem[w_vi] <= r_scount + CNT40_W'(w_len_cur) * CNT40_W'(r_life);
        end
        r_ptr_q <= r_ptr_mem[w_vi];
        r_exp_q <= r_exp_mem[w_vi];
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_vol <= i_volume;
        end
        if (i_cmd.rd_a) begin
            r_pa  <= w_pa;
            r_nxt <= w_nxt;
        end
        if (i_cmd.rd_b) begin
            r_a <= r_store_q;
        end
        if (i_cmd.mul) begin
            r_prod <= w_sum * $signed({1'b0, r_gain});
        end
        if (i_cmd.mix) begin
            r_mix <= r_acc * MIX_SCALE;
        end
        if (i_cmd.fill) begin
            r_fill_addr <= addr_wrap(w_base[w_vi], r_elem);
            r_fill_data <= w_fprod[31:16];
        end
        if (i_cmd.out) begin
            o_audio_sample  <= sat16(48'(r_mix >>> 15));
            o_voices_active <= (r_cnt > CNT_W'(127)) ? 7'd127 : r_cnt[6:0];
        end
    end

    // Control state and configuration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain      <= GAIN_RST;
            r_life      <= LIFE_RST;
            r_lfsr      <= 32'd1;
            r_pvalid    <= '0;
            r_active    <= '0;
            r_scount    <= '0;
            r_acc       <= '0;
            r_cnt       <= '0;
            r_elem      <= '0;
            r_fill_pend <= 1'b0;
            o_strobe    <= 1'b0;
        end else begin
            o_strobe    <= i_cmd.out;
            r_fill_pend <= i_cmd.fill;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_DAMPING: r_gain <= i_cfg_data[14:0];
                    REG_LIFE:    r_life <= i_cfg_data[9:0];
                    REG_SEED:    r_lfsr <= (i_cfg_data == 32'd0) ? 32'd1 : i_cfg_data;
                    default:     ;
                endcase
            end
            if (i_cmd.latch) begin
                r_elem <= '0;
            end
            if (i_cmd.fill) begin
                r_lfsr <= w_lfsr_n;
                r_elem <= r_elem + ELEM_W'(1);
            end
            if (i_cmd.pluck_end) begin
                r_active[w_vi] <= 1'b1;
            end
            if (i_cmd.start_tick) begin
                r_acc <= '0;
                r_cnt <= '0;
            end
            if (i_cmd.wr_step) begin
                r_pvalid[w_vi] <= 1'b1;
                r_acc <= r_acc + ACC_W'(w_y);
                if (w_retire) begin
                    r_active[w_vi] <= 1'b0;
                end else begin
                    r_cnt <= r_cnt + CNT_W'(1);
                end
            end
            if (i_cmd.out) begin
                r_scount <= r_scount + CNT40_W'(1);
            end
        end
    end

endmodule

### sv/plucked_string_voice_bank_unit.sv
`timescale 1ns / 1ps
// Channel      Direction  Ports                                   Handshake
// request      in         i_opcode, i_note_number, i_volume       start / busy
// result       out        o_audio_sample, o_voices_active         o_strobe
// config       in         i_cfg_index, i_cfg_data                 i_cfg_valid / o_cfg_ready
//
// A tick visits S_CHK for an idle voice and S_CHK, S_PTR, S_A, S_B and S_W for an active one,
// then S_MIX and S_OUT; its result strobes the cycle after S_OUT.
// A pluck writes one noise element per cycle over the voice's line.
// Reset is synchronous and active low; the store needs no clearing pass after it.
// The result receiver cannot stall; the config port is always ready.

module plucked_string_voice_bank_unit import psvb_pkg::*; #(
    parameter int VOICES      = VOICES_DEF,
    parameter int STORE_DEPTH = STORE_DEPTH_DEF,
    parameter int MAX_LINE    = MAX_LINE_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic                 i_opcode,
    input  logic [6:0]           i_note_number,
    input  logic [14:0]          i_volume,
    output logic signed [15:0]   o_audio_sample,
    output logic [6:0]           o_voices_active,
    output logic                 o_strobe,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data
);

    t_cmd  w_cmd;
    t_stat w_stat;

    // Configuration writes go straight into registers, so the port never pushes back.
    assign o_cfg_ready = 1'b1;

    // The controller sequences a request: a pluck sweeps the voice's line, a tick
    // visits every voice in turn and then mixes the accumulated steps.
    psvb_ctrl #(
        .VOICES(VOICES)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_opcode     (i_opcode),
        .i_note_number(i_note_number),
        .i_stat       (w_stat),
        .o_cmd        (w_cmd),
        .o_busy       (busy)
    );

    // The datapath owns the delay-line store, the per-voice tables, the noise
    // generator and the multipliers for damping, noise scaling and mixing.
    psvb_dp #(
        .VOICES     (VOICES),
        .STORE_DEPTH(STORE_DEPTH),
        .MAX_LINE   (MAX_LINE)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_volume       (i_volume),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .o_audio_sample (o_audio_sample),
        .o_voices_active(o_voices_active),
        .o_strobe       (o_strobe)
    );

`ifndef NO_ASSERTIONS
    // A result only follows work in progress.
    a_strobe_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(busy))
        else $error("result without a request in progress");

    // Results are never back to back.
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("two results in a row");

    // An accepted tick keeps the block busy.
    a_tick_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_opcode == OP_TICK) |=> busy)
        else $error("tick request did not start");

    // A pluck never produces a result.
    a_pluck_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.fill |-> !o_strobe)
        else $error("result during a pluck");
`endif

endmodule

### tb/sv/plucked_string_voice_bank_unit_tb.sv
`timescale 1ns / 1ps

module plucked_string_voice_bank_unit_tb;
    import psvb_pkg::*;

    localparam int NVOICE    = 120;
    localparam int DEPTH     = 131072;
    localparam int LONGEST   = 2756;
    localparam int MIX_GAIN  = 32766;
    localparam int IDLE_WAIT = 3000;   // longest pluck plus margin
    localparam int WD_LIMIT  = 20000;

    // One mixed sample as the block should report it after a tick.
    typedef struct {
        logic signed [15:0] sample;
        logic [6:0]         active;
    } mix_t;

    // Shadow copy of the voice bank. It updates its own state for every
    // accepted request and queues the mixed sample that each tick should give.
    class voice_bank_sb;
        logic signed [15:0] store [DEPTH];
        int                 base_of [NVOICE];
        int                 len_of [NVOICE];
        int                 ptr [NVOICE];
        bit                 on [NVOICE];
        logic [39:0]        expiry [NVOICE];
        logic [39:0]        ticks;
        logic [31:0]        noise;
        logic [14:0]        gain;
        logic [9:0]         life;
        mix_t               pending [$];
        int                 errors;

        function new();
            int b;
            b = 0;
            for (int v = 0; v < NVOICE; v++) begin
                len_of[v]  = (int'(LEN_ROM[v]) > LONGEST) ? LONGEST : int'(LEN_ROM[v]);
                base_of[v] = b;
                b          = (b + len_of[v]) % DEPTH;
                ptr[v]     = 0;
                on[v]      = 0;
                expiry[v]  = '0;
            end
            ticks  = '0;
            noise  = 32'd1;
            gain   = GAIN_RST;
            life   = LIFE_RST;
            errors = 0;
        endfunction

        function automatic logic signed [15:0] clip(longint x);
            if (x > 32767) return 16'sh7fff;
            if (x < -32768) return 16'sh8000;
            return x[15:0];
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
            case (idx)
                REG_DAMPING: gain = val[14:0];
                REG_LIFE:    life = val[9:0];
                REG_SEED:    noise = (val == 0) ? 32'd1 : val;
                default: ;
            endcase
        endfunction

        function void note_request(logic op, logic [6:0] note, logic [14:0] vol);
            longint acc, r, s;
            int     p, q, a;
            mix_t   m;
            logic signed [15:0] y;
            logic [39:0] diff;
            if (op == OP_PLUCK) begin
                // Out-of-range notes are dropped without touching any state.
                if (note >= NVOICE) return;
                for (int i = 0; i < len_of[note]; i++) begin
                    noise = noise[0] ? ({1'b0, noise[31:1]} ^ LFSR_TAPS)
                                     : {1'b0, noise[31:1]};
                    r = longint'($signed(noise[31:16]));
                    store[(base_of[note] + i) % DEPTH] = (r * longint'(vol)) >>> 16;
                end
                on[note]     = 1;
                expiry[note] = ticks + 40'(len_of[note]) * 40'(life);
                return;
            end
            acc = 0;
            for (int v = 0; v < NVOICE; v++) begin
                if (!on[v]) continue;
                p = (ptr[v] >= len_of[v]) ? 0 : ptr[v];
                q = (p + 1 >= len_of[v]) ? 0 : p + 1;
                a = (base_of[v] + p) % DEPTH;
                s = longint'(store[a]) + longint'(store[(base_of[v] + q) % DEPTH]);
                y = clip((s * longint'(gain)) >>> 15);
                store[a] = y;
                ptr[v]   = q;
                acc += y;
            end
            m.sample = clip((acc * MIX_GAIN) >>> 15);
            m.active = 0;
            // Retirement uses a modular 40-bit compare against the next count.
            for (int v = 0; v < NVOICE; v++) begin
                if (!on[v]) continue;
                diff = ticks + 40'd1 - expiry[v];
                if (!diff[39]) on[v] = 0;
                else m.active++;
            end
            ticks++;
            pending.push_back(m);
        endfunction

        function void check_result(logic signed [15:0] smp, logic [6:0] act);
            mix_t m;
            if (pending.size() == 0) begin
                $error("audio_sample: unexpected result, actual %0d", smp);
                errors++;
                return;
            end
            m = pending.pop_front();
            if (smp !== m.sample) begin
                $error("audio_sample: expected %0d, actual %0d", m.sample, smp);
                errors++;
            end
            if (act !== m.active) begin
                $error("voices_active: expected %0d, actual %0d", m.active, act);
                errors++;
            end
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    logic                 i_opcode;
    logic [6:0]           i_note_number;
    logic [14:0]          i_volume;
    logic signed [15:0]   o_audio_sample;
    logic [6:0]           o_voices_active;
    logic                 o_strobe;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [31:0]          i_cfg_data;

    voice_bank_sb bank;
    int           quiet_cycles;
    int           burst_left;

    plucked_string_voice_bank_unit dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Results cannot be held off, so every strobe is checked on the edge
    // that ends its cycle.
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            bank.check_result(o_audio_sample, o_voices_active);
        end
    end

    // The watchdog restarts on any request, result or register write.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WD_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // Writes one register; called only while the bank is idle. Valid drops
    // before the next write can start.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        bank.set_reg(idx, val);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Presents one request and holds it until the block takes it. Start
    // stays high into the next request while a burst lasts; between bursts,
    // if gaps are enabled, it drops for a random gap that may be zero.
    task automatic send(logic op, logic [6:0] note, logic [14:0] vol, bit gaps);
        int gap;
        start         <= 1'b1;
        i_opcode      <= op;
        i_note_number <= note;
        i_volume      <= vol;
        do @(posedge i_clk); while (busy);
        bank.note_request(op, note, vol);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(1, 16);
            gap = gaps ? $urandom_range(0, 8) : 0;
            if (gap > 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // Waits out every expected sample, then the longest pluck, since a
    // pluck gives no result to wait on.
    task automatic settle();
        start <= 1'b0;
        @(posedge i_clk);
        while (bank.pending.size() != 0) @(posedge i_clk);
        repeat (IDLE_WAIT) @(posedge i_clk);
    endtask

    task automatic random_requests(int n);
        logic [6:0]  note;
        logic [14:0] vol;
        int          pick;
        bit          gaps;
        gaps = $urandom_range(0, 3) != 0;
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 99) < 55) begin
                send(OP_TICK, 7'($urandom), 15'($urandom), gaps);
            end else begin
                // Mostly short lines so the run stays brief; the long
                // bass lines and ignored notes still appear.
                pick = $urandom_range(0, 99);
                if (pick < 4)       note = $urandom_range(0, 11);
                else if (pick < 16) note = $urandom_range(12, 39);
                else                note = $urandom_range(40, 127);
                pick = $urandom_range(0, 9);
                vol  = (pick == 0) ? 15'd0 : (pick == 1) ? 15'h7fff : 15'($urandom);
                send(OP_PLUCK, note, vol, gaps);
            end
        end
    endtask

    initial begin
        bank          = new();
        quiet_cycles  = 0;
        burst_left    = 0;
        i_rst_n       = 1'b0;
        start         = 1'b0;
        i_opcode      = OP_TICK;
        i_note_number = '0;
        i_volume      = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = REG_DAMPING;
        i_cfg_data    = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part at reset settings: full and zero volume, the
        // lowest and highest notes, ignored notes and a repluck.
        send(OP_TICK, 7'd0, 15'd0, 0);
        send(OP_PLUCK, 7'd119, 15'h7fff, 0);
        send(OP_TICK, 7'h7f, 15'h7fff, 0);
        send(OP_PLUCK, 7'd0, 15'h7fff, 0);
        send(OP_PLUCK, 7'd127, 15'h7fff, 1);
        send(OP_PLUCK, 7'd120, 15'd1, 0);
        send(OP_PLUCK, 7'd60, 15'd0, 0);
        send(OP_PLUCK, 7'd11, 15'd1, 0);
        send(OP_PLUCK, 7'd12, 15'h4000, 0);
        repeat (4) send(OP_TICK, 7'd0, 15'd0, 1);
        send(OP_PLUCK, 7'd119, 15'h2aaa, 0);
        repeat (3) send(OP_TICK, 7'h55, 15'h5555, 0);
        settle();

        // Full gain, zero lifetime and a zero seed: every voice sounds once.
        write_reg(REG_DAMPING, 32'd32767);
        write_reg(REG_LIFE, 32'd0);
        write_reg(REG_SEED, 32'd0);
        send(OP_PLUCK, 7'd100, 15'h7fff, 0);
        send(OP_PLUCK, 7'd110, 15'h7fff, 0);
        send(OP_TICK, 7'd0, 15'd0, 0);
        send(OP_TICK, 7'd0, 15'd0, 0);
        random_requests(300);
        settle();

        // Silence the feedback and use the shortest nonzero lifetime.
        write_reg(REG_DAMPING, 32'd0);
        write_reg(REG_LIFE, 32'd1);
        write_reg(REG_SEED, 32'hffff_ffff);
        random_requests(300);
        settle();

        write_reg(REG_DAMPING, 32'($urandom_range(0, 32767)));
        write_reg(REG_LIFE, 32'($urandom_range(1, 4)));
        write_reg(REG_SEED, $urandom);
        random_requests(450);
        settle();

        // Longest lifetime lets voices pile up across the whole bank.
        write_reg(REG_DAMPING, 32'd32767);
        write_reg(REG_LIFE, 32'd1023);
        write_reg(REG_SEED, $urandom);
        random_requests(580);
        settle();

        if (bank.errors == 0 && bank.pending.size() == 0) begin
            $display("No mismatches found");
        end else begin
            if (bank.pending.size() != 0) begin
                $error("audio_sample: %0d results never arrived", bank.pending.size());
            end
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
